// ===== hw/rtl/tpcis_pkg.sv =====
// ----------------------------------------------------------------------------
// tpcis_pkg - shared definitions for the trusted proxy client address select
// Sizes, operation and status codes, and the command and status words that
// join the controller to the datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tpcis_pkg;

  // Trusted network table
  localparam int TABLE_ENTRIES = 16;
  localparam int TBL_AW        = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1);

  // Forwarded chain
  localparam int MAX_CHAIN_LEN = 64;
  localparam int CHAIN_W       = $clog2(MAX_CHAIN_LEN + 1);

  // Field widths
  localparam int ADDR_W = 64;
  localparam int HALF_W = 32;
  localparam int PFX_W  = 8;
  localparam int IDX_W  = 4;
  localparam int ACT_W  = 5;
  localparam int OP_W   = 2;
  localparam int STS_W  = 2;

  // Largest legal prefix per family
  localparam logic [PFX_W-1:0] V4_MAX_PFX = 8'd32;
  localparam logic [PFX_W-1:0] V6_MAX_PFX = 8'd128;

  // Operation codes
  localparam logic [OP_W-1:0] OP_LOAD  = 2'd0;
  localparam logic [OP_W-1:0] OP_PEER  = 2'd1;
  localparam logic [OP_W-1:0] OP_CHAIN = 2'd2;

  // Result status codes
  localparam logic [STS_W-1:0] RES_OK         = 2'd0;
  localparam logic [STS_W-1:0] RES_TOO_LONG   = 2'd1;
  localparam logic [STS_W-1:0] RES_BAD_PREFIX = 2'd2;

  // Controller to datapath
  typedef struct packed {
    logic capture;
    logic search_start;
    logic search_run;
    logic update;
    logic tbl_write;
    logic out_load;
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic search_done;
    logic out_free;
    logic last;
  } dp_sts_t;

endpackage

// ===== hw/rtl/tpcis_dp.sv =====
// ----------------------------------------------------------------------------
// tpcis_dp - datapath of the trusted proxy client address select
// Holds the input word, the trusted network table, the table search pipe,
// the request state and the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tpcis_dp (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic [tpcis_pkg::OP_W-1:0]            op,
  input  logic [tpcis_pkg::ADDR_W-1:0]          addr_hi,
  input  logic [tpcis_pkg::ADDR_W-1:0]          addr_lo,
  input  logic                                  is_v6,
  input  logic [tpcis_pkg::PFX_W-1:0]           prefix_len,
  input  logic [tpcis_pkg::IDX_W-1:0]           entry_index,
  input  logic                                  last,
  input  logic                                  cfg_wr_en,
  input  logic [tpcis_pkg::ACT_W-1:0]           cfg_wr_data,
  input  tpcis_pkg::dp_cmd_t                    cmd,
  output tpcis_pkg::dp_sts_t                    sts,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic [tpcis_pkg::STS_W-1:0]           status,
  output logic [tpcis_pkg::ADDR_W-1:0]          result_addr_hi,
  output logic [tpcis_pkg::ADDR_W-1:0]          result_addr_lo,
  output logic                                  result_is_v6,
  output logic                                  from_chain
);

  import tpcis_pkg::*;

  typedef struct packed {
    logic [ADDR_W-1:0] hi;
    logic [ADDR_W-1:0] lo;
    logic [PFX_W-1:0]  prefix;
    logic              fam;
  } entry_t;

  function automatic logic [ADDR_W-1:0] mask_upper(input logic [PFX_W-1:0] p);
    logic [ADDR_W-1:0] m;
    for (int i = 0; i < ADDR_W; i++) m[i] = ((int'(p) + i) >= ADDR_W);
    return m;
  endfunction

  function automatic logic [ADDR_W-1:0] mask_lower(input logic [PFX_W-1:0] p);
    logic [ADDR_W-1:0] m;
    for (int i = 0; i < ADDR_W; i++) m[i] = ((int'(p) + i) >= 2 * ADDR_W);
    return m;
  endfunction

  // Normalised input address
  logic [ADDR_W-1:0] n_hi, n_lo;
  logic              n_v6;

  // Captured word
  logic [OP_W-1:0]   it_op;
  logic [ADDR_W-1:0] it_hi, it_lo;
  logic              it_v6;
  logic [PFX_W-1:0]  it_pfx;
  logic [IDX_W-1:0]  it_idx;
  logic              it_last;

  // Configuration
  logic [ACT_W-1:0]  active_entries;
  logic [CNT_W-1:0]  n_act;

  // Table and search
  entry_t            tbl [TABLE_ENTRIES];
  entry_t            rd_entry;
  logic              rd_v;
  logic [CNT_W-1:0]  cnt;
  logic              hit;
  logic              match;
  logic              bad_pfx;
  logic              tbl_we;

  // Request state
  logic [ADDR_W-1:0]  peer_hi, peer_lo;
  logic               peer_v6, peer_trust;
  logic [CHAIN_W-1:0] chain_len;
  logic               chain_ovf;
  logic [ADDR_W-1:0]  cand_hi, cand_lo;
  logic               cand_v6, cand_valid;
  logic [ADDR_W-1:0]  first_hi, first_lo;
  logic               first_v6;

  // Result selection
  logic [STS_W-1:0]   res_status;
  logic [ADDR_W-1:0]  res_hi, res_lo;
  logic               res_v6, res_fc;

  // Fold IPv4 and IPv4-mapped IPv6 into one form
  always_comb begin
    n_hi = addr_hi;
    n_lo = addr_lo;
    n_v6 = is_v6;
    if (!is_v6) begin
      n_hi = {addr_hi[ADDR_W-1:HALF_W], {HALF_W{1'b0}}};
      n_lo = '0;
    end else if (addr_hi == '0 && addr_lo[ADDR_W-1:HALF_W] == 32'h0000_ffff) begin
      n_hi = {addr_lo[HALF_W-1:0], {HALF_W{1'b0}}};
      n_lo = '0;
      n_v6 = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      it_op   <= op;
      it_hi   <= n_hi;
      it_lo   <= n_lo;
      it_v6   <= n_v6;
      it_pfx  <= prefix_len;
      it_idx  <= entry_index;
      it_last <= last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active_entries <= '0;
    end else if (cfg_wr_en) begin
      active_entries <= cfg_wr_data;
    end
  end

  assign n_act = (int'(active_entries) > TABLE_ENTRIES) ? CNT_W'(TABLE_ENTRIES)
                                                        : CNT_W'(active_entries);

  // Table load
  assign bad_pfx = it_pfx > (it_v6 ? V6_MAX_PFX : V4_MAX_PFX);
  assign tbl_we  = cmd.tbl_write && !bad_pfx && (int'(it_idx) < TABLE_ENTRIES);

  always_ff @(posedge clk) begin
    if (tbl_we) begin
      tbl[TBL_AW'(it_idx)] <= '{hi:     it_hi & mask_upper(it_pfx),
                                lo:     it_lo & mask_lower(it_pfx),
                                prefix: it_pfx,
                                fam:    it_v6};
    end
    rd_entry <= tbl[cnt[TBL_AW-1:0]];
  end

  // One entry read per cycle, compared on the next
  assign match = rd_v && (rd_entry.fam == it_v6) &&
                 ((it_hi & mask_upper(rd_entry.prefix)) == rd_entry.hi) &&
                 ((it_lo & mask_lower(rd_entry.prefix)) == rd_entry.lo);

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      rd_v <= 1'b0;
      hit  <= 1'b0;
    end else if (cmd.search_start) begin
      cnt  <= '0;
      rd_v <= 1'b0;
      hit  <= 1'b0;
    end else if (cmd.search_run) begin
      if (cnt < n_act) begin
        cnt  <= cnt + 1'b1;
        rd_v <= 1'b1;
      end else begin
        rd_v <= 1'b0;
      end
      if (match) hit <= 1'b1;
    end
  end

  // Request state
  always_ff @(posedge clk) begin
    if (rst) begin
      peer_hi    <= '0;
      peer_lo    <= '0;
      peer_v6    <= 1'b0;
      peer_trust <= 1'b0;
      chain_len  <= '0;
      chain_ovf  <= 1'b0;
      cand_hi    <= '0;
      cand_lo    <= '0;
      cand_v6    <= 1'b0;
      cand_valid <= 1'b0;
      first_hi   <= '0;
      first_lo   <= '0;
      first_v6   <= 1'b0;
    end else if (cmd.update) begin
      case (it_op)
        OP_PEER: begin
          peer_hi    <= it_hi;
          peer_lo    <= it_lo;
          peer_v6    <= it_v6;
          peer_trust <= hit;
          chain_len  <= '0;
          chain_ovf  <= 1'b0;
          cand_hi    <= '0;
          cand_lo    <= '0;
          cand_v6    <= 1'b0;
          cand_valid <= 1'b0;
          first_hi   <= '0;
          first_lo   <= '0;
          first_v6   <= 1'b0;
        end
        OP_CHAIN: begin
          if (peer_trust) begin
            if (chain_len >= CHAIN_W'(MAX_CHAIN_LEN)) begin
              chain_ovf <= 1'b1;
            end else begin
              if (chain_len == '0) begin
                first_hi <= it_hi;
                first_lo <= it_lo;
                first_v6 <= it_v6;
              end
              chain_len <= chain_len + 1'b1;
              if (!hit) begin
                cand_hi    <= it_hi;
                cand_lo    <= it_lo;
                cand_v6    <= it_v6;
                cand_valid <= 1'b1;
              end
            end
          end
        end
        default: begin
        end
      endcase
    end else if (cmd.out_load && it_op != OP_LOAD) begin
      // drop chain state once the request ends; keep the peer
      chain_len  <= '0;
      chain_ovf  <= 1'b0;
      cand_hi    <= '0;
      cand_lo    <= '0;
      cand_v6    <= 1'b0;
      cand_valid <= 1'b0;
      first_hi   <= '0;
      first_lo   <= '0;
      first_v6   <= 1'b0;
    end
  end

  // Result word
  always_comb begin
    res_status = RES_OK;
    res_hi     = '0;
    res_lo     = '0;
    res_v6     = 1'b0;
    res_fc     = 1'b0;
    if (it_op == OP_LOAD) begin
      res_status = bad_pfx ? RES_BAD_PREFIX : RES_OK;
    end else if (!peer_trust || chain_len == '0) begin
      res_hi = peer_hi;
      res_lo = peer_lo;
      res_v6 = peer_v6;
    end else if (chain_ovf) begin
      res_status = RES_TOO_LONG;
    end else if (cand_valid) begin
      res_hi = cand_hi;
      res_lo = cand_lo;
      res_v6 = cand_v6;
      res_fc = 1'b1;
    end else begin
      res_hi = first_hi;
      res_lo = first_lo;
      res_v6 = first_v6;
      res_fc = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      status         <= res_status;
      result_addr_hi <= res_hi;
      result_addr_lo <= res_lo;
      result_is_v6   <= res_v6;
      from_chain     <= res_fc;
    end
  end

  assign sts.search_done = hit || (cnt == n_act && !rd_v);
  assign sts.out_free    = !out_valid || !out_stall;
  assign sts.last        = it_last;

  a_chain_bound: assert property (@(posedge clk) disable iff (rst)
    chain_len <= CHAIN_W'(MAX_CHAIN_LEN))
    else $error("chain length ran past its limit");

  a_ovf_full: assert property (@(posedge clk) disable iff (rst)
    chain_ovf |-> (chain_len == CHAIN_W'(MAX_CHAIN_LEN)))
    else $error("overflow flagged on a chain that is not full");

  a_cand_in_chain: assert property (@(posedge clk) disable iff (rst)
    cand_valid |-> (chain_len != '0 && peer_trust))
    else $error("candidate held without a chain behind a trusted peer");

endmodule

// ===== hw/rtl/tpcis_ctrl.sv =====
// ----------------------------------------------------------------------------
// tpcis_ctrl - controller of the trusted proxy client address select
// Sequences word capture, table load, table search and result hand-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tpcis_ctrl (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  input  logic [tpcis_pkg::OP_W-1:0] op,
  output logic                       in_stall,
  output tpcis_pkg::dp_cmd_t         cmd,
  input  tpcis_pkg::dp_sts_t         sts
);

  import tpcis_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_LOAD   = 4'b0010,
    ST_SEARCH = 4'b0100,
    ST_EMIT   = 4'b1000
  } state_t;

  state_t state, state_next;
  logic   accept;

  assign in_stall = (state != ST_IDLE);
  assign accept   = in_valid && (state == ST_IDLE);

  always_comb begin
    state_next       = state;
    cmd              = '0;
    cmd.capture      = accept;
    cmd.search_start = accept;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          unique case (op) inside
            OP_LOAD:            state_next = ST_LOAD;
            OP_PEER, OP_CHAIN:  state_next = ST_SEARCH;
            default:            state_next = ST_IDLE;
          endcase
        end
      end
      ST_LOAD: begin
        cmd.tbl_write = 1'b1;
        state_next    = ST_EMIT;
      end
      ST_SEARCH: begin
        cmd.search_run = 1'b1;
        if (sts.search_done) begin
          cmd.update = 1'b1;
          state_next = sts.last ? ST_EMIT : ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  a_load_path: assert property (@(posedge clk) disable iff (rst)
    (accept && op == OP_LOAD) |=> ##1 (state == ST_EMIT))
    else $error("load word did not reach the result stage after one write cycle");

endmodule

// ===== hw/rtl/trusted_proxy_client_ip_select.sv =====
// ----------------------------------------------------------------------------
// trusted_proxy_client_ip_select - client address selection behind proxies
// Keeps a table of up to sixteen trusted IPv4/IPv6 networks and picks the
// client address of a request: the peer word comes first, then the forwarded
// chain words in header order, the final one marked by last. IPv4-mapped IPv6
// addresses are folded to IPv4. An untrusted peer, or a peer with no chain,
// is its own answer; a chain of more than 64 words gives a too-long status;
// otherwise the rightmost untrusted chain address wins, or the leftmost if
// the whole chain is trusted. Every load word returns one status word; an
// address word returns a word only when it carries last. The block takes one
// word at a time. A load word is captured, written to the table if its prefix
// is legal, and then gets its result. Peer and chain words search the table
// entries in use (active_entries, clamped to 16): the table sits in one
// memory with a registered read port, searched one entry per cycle, and the
// search stops at the first matching entry. A word that ends in a result also
// waits in its result state for as long as an earlier result is still held in
// the output register by a stalled receiver. Chain words behind an untrusted
// peer still run the search but change nothing. The result sits in an output
// register, so the next word is taken while a finished result waits for its
// receiver.
// Write active_entries only while the block is idle. There is no clearing
// pass after reset; table slots must be loaded before they are brought into
// use.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module trusted_proxy_client_ip_select (
  input  logic                         clk,
  input  logic                         rst,
  // configuration
  input  logic                         cfg_wr_en,
  input  logic [tpcis_pkg::ACT_W-1:0]  cfg_wr_data,
  // input words
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [tpcis_pkg::OP_W-1:0]   op,
  input  logic [tpcis_pkg::ADDR_W-1:0] addr_hi,
  input  logic [tpcis_pkg::ADDR_W-1:0] addr_lo,
  input  logic                         is_v6,
  input  logic [tpcis_pkg::PFX_W-1:0]  prefix_len,
  input  logic [tpcis_pkg::IDX_W-1:0]  entry_index,
  input  logic                         last,
  // result words
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [tpcis_pkg::STS_W-1:0]  status,
  output logic [tpcis_pkg::ADDR_W-1:0] result_addr_hi,
  output logic [tpcis_pkg::ADDR_W-1:0] result_addr_lo,
  output logic                         result_is_v6,
  output logic                         from_chain
);

  import tpcis_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  // Controller: decide the op at capture, walk load / search / hand-off
  tpcis_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .op       (op),
    .in_stall (in_stall),
    .cmd      (cmd),
    .sts      (sts)
  );

  // Datapath: normalise and hold the word, search the table, keep the
  // request state and drive the output register
  tpcis_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .op             (op),
    .addr_hi        (addr_hi),
    .addr_lo        (addr_lo),
    .is_v6          (is_v6),
    .prefix_len     (prefix_len),
    .entry_index    (entry_index),
    .last           (last),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .cmd            (cmd),
    .sts            (sts),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .status         (status),
    .result_addr_hi (result_addr_hi),
    .result_addr_lo (result_addr_lo),
    .result_is_v6   (result_is_v6),
    .from_chain     (from_chain)
  );

endmodule
